/* sv/ckbb_pkg.sv */
// Package for the color keyed bounding box tracker.
// Holds field widths, status and action codes, and the cell types.
// No dependencies.
package ckbb_pkg;

   // Field widths fixed by the interface
   localparam int COLOR_W  = 24;
   localparam int COL_W    = 6;
   localparam int ROW_W    = 5;
   localparam int LABEL_W  = 4;
   localparam int STATUS_W = 3;
   localparam int ACTION_W = 2;
   localparam int X_W      = 9;
   localparam int Y_W      = 8;
   localparam int SHIFT_W  = 3;
   localparam int CSR_IDX_W = 2;

   // Saturation points that keep the end column and end row in range
   localparam int COL_SAT    = 62;
   localparam int ROW_SAT    = 30;
   localparam int MAX_SHIFT  = 4;
   localparam int DUMP_LIMIT = 16;

   // Defaults for the top level parameters
   localparam int MAX_ENTRIES_DEF  = 16;
   localparam int FRAME_WIDTH_DEF  = 320;
   localparam int FRAME_HEIGHT_DEF = 200;

   // Register reset values
   localparam logic [COLOR_W-1:0] BACKGROUND_RESET = '0;
   localparam logic [SHIFT_W-1:0] CELL_SHIFT_RESET = 3'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SHIFT = 2'd1;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_PIXEL = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DUMP  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_MATCHED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEW        = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BACKGROUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DUMP_ENTRY = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DUMP_EMPTY = 3'd5;
   localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd6;

   // One table entry: color and bounding box in cell units
   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [COL_W-1:0]   min_col;
      logic [COL_W-1:0]   end_col;
      logic [ROW_W-1:0]   min_row;
      logic [ROW_W-1:0]   end_row;
   } entry_type;

   // Per-cell control from the top level
   typedef struct packed {
      logic rotate;   // take the neighbor's entry (dump)
      logic write;    // load the pixel as a new entry
      logic lookup;   // compare and merge the pixel if the color matches
   } cell_ctrl_type;

endpackage

/* sv/ckbb_to_cell.sv */
// Pixel position to cell index conversion: clamp to the frame, shift, saturate.
// Depends on ckbb_pkg.
module ckbb_to_cell
   import ckbb_pkg::*;
#(
   parameter int FRAME = FRAME_WIDTH_DEF,
   parameter int POS_W = X_W,
   parameter int OUT_W = COL_W,
   parameter int SAT   = COL_SAT
) (
   input  logic [POS_W-1:0]   pos,
   input  logic [SHIFT_W-1:0] shift,
   output logic [OUT_W-1:0]   cell_idx
);

   localparam int FW = $clog2(FRAME);
   localparam int W  = (POS_W > FW) ? POS_W : FW;

   logic [W-1:0]       pos_ext;
   logic [W-1:0]       clamped;
   logic [W-1:0]       shifted;
   logic [SHIFT_W-1:0] sh;

   always_comb begin
      pos_ext = W'(pos);
      clamped = (pos_ext > W'(FRAME - 1)) ? W'(FRAME - 1) : pos_ext;
      sh      = (shift > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : shift;
      shifted = clamped >> sh;
      if (32'(shifted) > 32'(SAT)) begin
         cell_idx = OUT_W'(SAT);
      end else begin
         cell_idx = OUT_W'(shifted);
      end
   end

endmodule

/* sv/ckbb_cell.sv */
// One table cell: holds one entry, matches and merges pixels, rotates on dump.
// Depends on ckbb_pkg.
module ckbb_cell
   import ckbb_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     pix,       // pixel as a one-cell entry
   input  entry_type     neighbor,  // entry of the next cell in the ring
   output entry_type     entry,     // stored entry
   output entry_type     merged,    // stored entry grown by the pixel
   output logic          match
);

   entry_type entry_ff;
   entry_type entry_in;

   assign entry = entry_ff;
   assign match = ctrl.lookup && (entry_ff.color == pix.color);

   always_comb begin
      merged         = entry_ff;
      merged.min_col = (pix.min_col < entry_ff.min_col) ? pix.min_col : entry_ff.min_col;
      merged.end_col = (pix.end_col > entry_ff.end_col) ? pix.end_col : entry_ff.end_col;
      merged.min_row = (pix.min_row < entry_ff.min_row) ? pix.min_row : entry_ff.min_row;
      merged.end_row = (pix.end_row > entry_ff.end_row) ? pix.end_row : entry_ff.end_row;
   end

   always_comb begin
      if (ctrl.rotate) begin
         entry_in = neighbor;
      end else if (ctrl.write) begin
         entry_in = pix;
      end else if (match) begin
         entry_in = merged;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* sv/color_keyed_bounding_box_tracker.sv */
// Top level of the color keyed bounding box tracker: control, entry count,
// response registers and the ring of table cells.
// Depends on ckbb_pkg, ckbb_cell and ckbb_to_cell.
//
//   channel   ports                         handshake
//   -------   ---------------------------   ------------------------------
//   request   start, busy, req_*            taken when start && !busy
//   response  rsp_valid, rsp_*              one-cycle strobe, no back-pressure
//   config    csr_valid, csr_ready, csr_*   written when csr_valid && csr_ready
//
// A pixel or clear action gets its response in the cycle after the request, an
// unused action gets none, and a new request can be taken every cycle while busy is low.
// A dump of a nonempty table holds busy while the cell ring rotates once,
// one entry leaving cell 0 each cycle; its min(count, 16) responses are
// registered, each one following the step that reads it out, so with a full
// table the last one lands after busy drops. Reset empties the table (count to
// zero) and loads the register defaults; entry contents are not cleared. The
// response side cannot stall, so nothing waits on it.
module color_keyed_bounding_box_tracker
   import ckbb_pkg::*;
#(
   parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
   parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request
   input  logic                 start,
   output logic                 busy,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [COLOR_W-1:0]   req_pixel_color,
   input  logic [X_W-1:0]       req_pixel_x,
   input  logic [Y_W-1:0]       req_pixel_y,
   // response
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [LABEL_W-1:0]   rsp_label,
   output logic [COLOR_W-1:0]   rsp_entry_color,
   output logic [COL_W-1:0]     rsp_box_min_col,
   output logic [COL_W-1:0]     rsp_box_end_col,
   output logic [ROW_W-1:0]     rsp_box_min_row,
   output logic [ROW_W-1:0]     rsp_box_end_row,
   output logic                 rsp_last,
   // configuration
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_data
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);                      // count width
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;  // index width

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type          state_ff;
   logic [CW-1:0]      count_ff;
   logic [IW-1:0]      step_ff;      // dump step, also the label leaving cell 0
   logic [CW-1:0]      dump_n_ff;    // responses to send in this dump
   logic [COLOR_W-1:0] background_ff;
   logic [SHIFT_W-1:0] cell_shift_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [LABEL_W-1:0]  rsp_label_ff;
   entry_type           rsp_entry_ff;
   logic                rsp_last_ff;

   logic               accept;
   logic               is_pixel;
   logic               is_background;
   logic               any_hit;
   logic               table_full;
   logic [CW-1:0]      dump_n;
   logic [COL_W-1:0]   pix_col;
   logic [ROW_W-1:0]   pix_row;
   entry_type          pix_entry;
   entry_type          hit_entry;
   logic [LABEL_W-1:0] hit_label;

   logic          [MAX_ENTRIES-1:0] hit_vec;
   cell_ctrl_type                   cell_ctrl [MAX_ENTRIES];
   entry_type                       cell_entry [MAX_ENTRIES];
   entry_type                       cell_merged [MAX_ENTRIES];

   assign busy      = (state_ff == S_DUMP);
   assign csr_ready = !busy;
   assign accept    = start && !busy;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_label       = rsp_label_ff;
   assign rsp_entry_color = rsp_entry_ff.color;
   assign rsp_box_min_col = rsp_entry_ff.min_col;
   assign rsp_box_end_col = rsp_entry_ff.end_col;
   assign rsp_box_min_row = rsp_entry_ff.min_row;
   assign rsp_box_end_row = rsp_entry_ff.end_row;
   assign rsp_last        = rsp_last_ff;

   // Convert the pixel position to cell units
   ckbb_to_cell #(
      .FRAME (FRAME_WIDTH),
      .POS_W (X_W),
      .OUT_W (COL_W),
      .SAT   (COL_SAT)
   ) u_col (
      .pos      (req_pixel_x),
      .shift    (cell_shift_ff),
      .cell_idx (pix_col)
   );

   ckbb_to_cell #(
      .FRAME (FRAME_HEIGHT),
      .POS_W (Y_W),
      .OUT_W (ROW_W),
      .SAT   (ROW_SAT)
   ) u_row (
      .pos      (req_pixel_y),
      .shift    (cell_shift_ff),
      .cell_idx (pix_row)
   );

   // The pixel as a box of one cell; saturation keeps the +1 in range
   always_comb begin
      pix_entry.color   = req_pixel_color;
      pix_entry.min_col = pix_col;
      pix_entry.end_col = pix_col + COL_W'(1);
      pix_entry.min_row = pix_row;
      pix_entry.end_row = pix_row + ROW_W'(1);
   end

   assign is_pixel      = accept && (req_action == ACT_PIXEL);
   assign is_background = (req_pixel_color == background_ff);
   assign table_full    = (count_ff >= CW'(MAX_ENTRIES));

   // Ring of cells: cell i takes cell i+1 on rotate, the last takes cell 0
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      always_comb begin
         cell_ctrl[i].rotate = (state_ff == S_DUMP);
         cell_ctrl[i].lookup = is_pixel && !is_background && (i < int'(count_ff));
         cell_ctrl[i].write  = is_pixel && !is_background && !any_hit
                               && (i == int'(count_ff));
      end

      ckbb_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl[i]),
         .pix      (pix_entry),
         .neighbor (cell_entry[(i + 1) % MAX_ENTRIES]),
         .entry    (cell_entry[i]),
         .merged   (cell_merged[i]),
         .match    (hit_vec[i])
      );
   end

   // Colors in the table are distinct, so at most one cell hits: OR the hit
   always_comb begin
      hit_entry = '0;
      hit_label = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (hit_vec[i]) begin
            hit_entry = hit_entry | cell_merged[i];
            hit_label = hit_label | LABEL_W'(i);
         end
      end
   end

   assign any_hit = |hit_vec;

   // Dump length: entry count capped at the dump limit
   assign dump_n = (int'(count_ff) > DUMP_LIMIT) ? CW'(DUMP_LIMIT) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         dump_n_ff     <= '0;
         background_ff <= BACKGROUND_RESET;
         cell_shift_ff <= CELL_SHIFT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // Drop the strobe unless something below raises it
         rsp_valid_ff <= 1'b0;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_BACKGROUND: background_ff <= csr_data;
               CSR_CELL_SHIFT: cell_shift_ff <= csr_data[SHIFT_W-1:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  // Default to a bare response; fill in below
                  rsp_status_ff <= ST_BACKGROUND;
                  rsp_label_ff  <= '0;
                  rsp_entry_ff  <= '0;
                  rsp_last_ff   <= 1'b1;
                  unique case (req_action)
                     ACT_PIXEL: begin
                        rsp_valid_ff <= 1'b1;
                        if (is_background) begin
                           rsp_status_ff <= ST_BACKGROUND;
                        end else if (any_hit) begin
                           rsp_status_ff <= ST_MATCHED;
                           rsp_label_ff  <= hit_label;
                           rsp_entry_ff  <= hit_entry;
                        end else if (table_full) begin
                           rsp_status_ff <= ST_FULL;
                        end else begin
                           rsp_status_ff <= ST_NEW;
                           rsp_label_ff  <= LABEL_W'(count_ff);
                           rsp_entry_ff  <= pix_entry;
                           count_ff      <= count_ff + CW'(1);
                        end
                     end
                     ACT_DUMP: begin
                        if (dump_n == '0) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= ST_DUMP_EMPTY;
                        end else begin
                           state_ff  <= S_DUMP;
                           step_ff   <= '0;
                           dump_n_ff <= dump_n;
                        end
                     end
                     ACT_CLEAR: begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= ST_CLEARED;
                        count_ff      <= '0;
                     end
                     default: ;  // unused action: no response, no change
                  endcase
               end
            end
            S_DUMP: begin
               // Report cell 0 while steps remain, keep rotating for a full turn
               if (CW'(step_ff) < dump_n_ff) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ST_DUMP_ENTRY;
                  rsp_label_ff  <= LABEL_W'(step_ff);
                  rsp_entry_ff  <= cell_entry[0];
                  rsp_last_ff   <= (CW'(step_ff) + CW'(1) == dump_n_ff);
               end
               if (step_ff == IW'(MAX_ENTRIES - 1)) begin
                  state_ff <= S_IDLE;
               end else begin
                  step_ff <= step_ff + IW'(1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell matched the pixel color");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(accept) || $past(state_ff == S_DUMP)))
      else $error("response without a request or dump step");

   a_new_grows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_NEW)
      |-> (count_ff == $past(count_ff) + CW'(1)))
      else $error("new entry reported without count advance");

   // While the ring is still turning, nothing may follow the last dump entry
   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff && rsp_status_ff == ST_DUMP_ENTRY && busy)
      |=> !rsp_valid_ff)
      else $error("response right after the last dump entry");
`endif

endmodule

/* bench/tb_color_keyed_bounding_box_tracker.sv */
// Self-checking bench for color_keyed_bounding_box_tracker: directed and random
// pixel, dump and clear requests against a cycle-free box tracking predictor.
// Depends on ckbb_pkg and the tracker RTL.
module tb_color_keyed_bounding_box_tracker;
   timeunit 1ns;
   timeprecision 1ps;
   import ckbb_pkg::*;

   // Codes the package leaves unnamed: the spare action and the spare register slot
   localparam logic [ACTION_W-1:0]  ACT_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // A dump keeps the block busy for one pass of the cell ring; allow that and a margin
   localparam int SETTLE_CYCLES = MAX_ENTRIES_DEF + 4;

   typedef enum logic [1:0] {OP_REQUEST, OP_CSR_WRITE, OP_WAIT_IDLE} op_kind_type;

   // One entry of the stimulus plan
   typedef struct {
      op_kind_type          kind;
      int unsigned          gap_pct;
      logic [ACTION_W-1:0]  action;
      logic [COLOR_W-1:0]   color;
      logic [X_W-1:0]       x;
      logic [Y_W-1:0]       y;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [COLOR_W-1:0]   csr_word;
   } stim_op_type;

   // One response as the tracker should report it
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LABEL_W-1:0]  label;
      entry_type           entry;
      logic                last;
   } report_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [ACTION_W-1:0]  req_action = '0;
   logic [COLOR_W-1:0]   req_pixel_color = '0;
   logic [X_W-1:0]       req_pixel_x = '0;
   logic [Y_W-1:0]       req_pixel_y = '0;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [LABEL_W-1:0]   rsp_label;
   logic [COLOR_W-1:0]   rsp_entry_color;
   logic [COL_W-1:0]     rsp_box_min_col;
   logic [COL_W-1:0]     rsp_box_end_col;
   logic [ROW_W-1:0]     rsp_box_min_row;
   logic [ROW_W-1:0]     rsp_box_end_row;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COLOR_W-1:0]   csr_data = '0;

   color_keyed_bounding_box_tracker dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_pixel_color (req_pixel_color),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_label       (rsp_label),
      .rsp_entry_color (rsp_entry_color),
      .rsp_box_min_col (rsp_box_min_col),
      .rsp_box_end_col (rsp_box_end_col),
      .rsp_box_min_row (rsp_box_min_row),
      .rsp_box_end_row (rsp_box_end_row),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // ------------------------------------------------------------------
   // Predictor state: registers, entry count and the color/box table
   // ------------------------------------------------------------------
   logic [COLOR_W-1:0] bg_color    = BACKGROUND_RESET;
   logic [SHIFT_W-1:0] cell_shift  = CELL_SHIFT_RESET;
   int unsigned        entry_total = 0;
   entry_type          box_table [MAX_ENTRIES_DEF];

   report_type  reports_due [$];   // responses owed by the tracker, oldest first
   stim_op_type plan [$];          // stimulus waiting for the driver
   int unsigned fail_count = 0;
   int unsigned settle_cnt = 0;
   bit          stim_done  = 1'b0;

   // Stimulus-side bookkeeping while the plan is built
   int unsigned        fill_gap_pct = 0;
   logic [COLOR_W-1:0] plan_bg      = BACKGROUND_RESET;

   // Random field values at the width of their ports
   function automatic logic [COLOR_W-1:0] rand_color();
      return COLOR_W'($urandom());
   endfunction

   function automatic logic [X_W-1:0] rand_x();
      return X_W'($urandom());
   endfunction

   function automatic logic [Y_W-1:0] rand_y();
      return Y_W'($urandom());
   endfunction

   // Clamp to the frame, scale down to cells, saturate so the end index still fits
   function automatic int pos_to_cell(int pos, int frame, int sat);
      int sh;
      sh = (cell_shift > MAX_SHIFT) ? MAX_SHIFT : int'(cell_shift);
      if (pos > frame - 1) pos = frame - 1;
      pos = pos >> sh;
      return (pos > sat) ? sat : pos;
   endfunction

   // Advance the table by one accepted request and queue the responses it owes
   task automatic track_request(input logic [ACTION_W-1:0] act, input logic [COLOR_W-1:0] color,
                                input logic [X_W-1:0] x, input logic [Y_W-1:0] y);
      report_type r;
      int         col, row, hit, n, i;
      r = '0;
      r.last = 1'b1;
      case (act)
         ACT_PIXEL: begin
            if (color == bg_color) begin
               r.status = ST_BACKGROUND;
               reports_due.push_back(r);
            end else begin
               col = pos_to_cell(int'(x), FRAME_WIDTH_DEF, COL_SAT);
               row = pos_to_cell(int'(y), FRAME_HEIGHT_DEF, ROW_SAT);
               hit = -1;
               for (i = 0; i < int'(entry_total); i++) begin
                  if (hit < 0 && box_table[i].color == color) hit = i;
               end
               if (hit >= 0) begin
                  // grow the existing box to cover this cell
                  if (col < box_table[hit].min_col) box_table[hit].min_col = COL_W'(col);
                  if (col + 1 > box_table[hit].end_col) box_table[hit].end_col = COL_W'(col + 1);
                  if (row < box_table[hit].min_row) box_table[hit].min_row = ROW_W'(row);
                  if (row + 1 > box_table[hit].end_row) box_table[hit].end_row = ROW_W'(row + 1);
                  r.status = ST_MATCHED;
                  r.label  = LABEL_W'(hit);
                  r.entry  = box_table[hit];
               end else if (entry_total >= MAX_ENTRIES_DEF) begin
                  r.status = ST_FULL;
               end else begin
                  box_table[entry_total] = '{color, COL_W'(col), COL_W'(col + 1),
                                             ROW_W'(row), ROW_W'(row + 1)};
                  r.status = ST_NEW;
                  r.label  = LABEL_W'(entry_total);
                  r.entry  = box_table[entry_total];
                  entry_total++;
               end
               reports_due.push_back(r);
            end
         end
         ACT_DUMP: begin
            n = (entry_total > DUMP_LIMIT) ? DUMP_LIMIT : int'(entry_total);
            if (n == 0) begin
               r.status = ST_DUMP_EMPTY;
               reports_due.push_back(r);
            end else begin
               for (i = 0; i < n; i++) begin
                  r.status = ST_DUMP_ENTRY;
                  r.label  = LABEL_W'(i);
                  r.entry  = box_table[i];
                  r.last   = (i == n - 1);
                  reports_due.push_back(r);
               end
            end
         end
         ACT_CLEAR: begin
            entry_total = 0;
            r.status = ST_CLEARED;
            reports_due.push_back(r);
         end
         default: ;   // spare action: no response, no state change
      endcase
   endtask

   task automatic apply_csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [COLOR_W-1:0] word);
      case (idx)
         CSR_BACKGROUND: bg_color = word;
         CSR_CELL_SHIFT: cell_shift = word[SHIFT_W-1:0];
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // Plan builders
   // ------------------------------------------------------------------
   task automatic add_request(input logic [ACTION_W-1:0] act, input logic [COLOR_W-1:0] color,
                              input logic [X_W-1:0] x, input logic [Y_W-1:0] y);
      stim_op_type op;
      op = '{OP_REQUEST, fill_gap_pct, act, color, x, y, '0, '0};
      plan.push_back(op);
   endtask

   task automatic add_idle_wait();
      stim_op_type op;
      op = '{OP_WAIT_IDLE, 0, '0, '0, '0, '0, '0, '0};
      plan.push_back(op);
   endtask

   // Registers only change once the tracker has drained, so always wait first
   task automatic add_csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [COLOR_W-1:0] word);
      stim_op_type op;
      add_idle_wait();
      op = '{OP_CSR_WRITE, 0, '0, '0, '0, '0, idx, word};
      plan.push_back(op);
      if (idx == CSR_BACKGROUND) plan_bg = word;
   endtask

   // Mostly well-formed frames: clear, a run of mostly pixels from a palette of up to 20
   // colors (it can fill the table), then a dump. The rest is loose random requests.
   task automatic add_random_traffic(input int unsigned target);
      logic [COLOR_W-1:0]  palette [20];
      logic [ACTION_W-1:0] act;
      int unsigned         made, k, len, j, pick;
      made = 0;
      while (made < target) begin
         if ($urandom_range(99) < 85) begin
            k = $urandom_range(20, 1);
            for (j = 0; j < k; j++) palette[j] = rand_color();
            add_request(ACT_CLEAR, rand_color(), rand_x(), rand_y());
            made++;
            len = $urandom_range(40, 4);
            for (j = 0; j < len; j++) begin
               pick = $urandom_range(99);
               if (pick < 6) begin
                  add_request(ACT_DUMP, rand_color(), rand_x(), rand_y());
                  made++;
               end else if (pick < 9) begin
                  add_request(ACT_UNUSED, rand_color(), rand_x(), rand_y());
               end else begin
                  add_request(ACT_PIXEL, (pick < 18) ? plan_bg : palette[$urandom_range(k - 1)],
                              X_W'($urandom_range(511)), Y_W'($urandom_range(255)));
                  made++;
               end
            end
            add_request(ACT_DUMP, rand_color(), rand_x(), rand_y());
            made++;
            if ($urandom_range(99) < 15) add_idle_wait();
         end else begin
            act = ACTION_W'($urandom_range(3));
            add_request(act, rand_color(), rand_x(), rand_y());
            if (act != ACT_UNUSED) made++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Stimulus plan: three idle settings, register changes between drains
   // ------------------------------------------------------------------
   initial begin
      logic [20:0] upper;

      // Phase one: sender idles about a fifth of the time, reset register values
      fill_gap_pct = 22;
      add_request(ACT_DUMP, 24'h0, 9'd0, 8'd0);               // dump of an empty table
      add_request(ACT_PIXEL, 24'h000000, 9'd5, 8'd5);         // background pixel
      add_request(ACT_PIXEL, 24'hFFFFFF, 9'd0, 8'd0);         // first entry at the origin
      add_request(ACT_PIXEL, 24'hFFFFFF, 9'd319, 8'd199);     // grow it to the far corner
      add_request(ACT_PIXEL, 24'h5A5A5A, 9'd511, 8'd255);     // outside the frame: clamp
      add_request(ACT_PIXEL, 24'hA5A5A5, 9'd256, 8'd128);
      add_request(ACT_UNUSED, 24'hC3C3C3, 9'd300, 8'd100);    // spare action, ignored
      add_request(ACT_DUMP, 24'hFFFFFF, 9'd511, 8'd255);
      add_request(ACT_CLEAR, 24'h123456, 9'd1, 8'd1);
      add_request(ACT_DUMP, 24'h0, 9'd0, 8'd0);

      // White becomes background; one-pixel cells push columns and rows into saturation
      upper = 21'($urandom());
      add_csr_write(CSR_BACKGROUND, 24'hFFFFFF);
      add_csr_write(CSR_CELL_SHIFT, {upper, 3'd0});
      add_request(ACT_PIXEL, 24'hFFFFFF, 9'd10, 8'd10);
      add_request(ACT_PIXEL, 24'h000000, 9'd319, 8'd199);
      add_request(ACT_PIXEL, 24'h000000, 9'd0, 8'd0);
      add_request(ACT_PIXEL, 24'h123456, 9'd40, 8'd20);
      add_request(ACT_DUMP, 24'h0, 9'd0, 8'd0);

      // Shift code above the largest cell size acts as the largest
      upper = 21'($urandom());
      add_csr_write(CSR_CELL_SHIFT, {upper, 3'd7});
      add_request(ACT_PIXEL, 24'h123456, 9'd319, 8'd199);
      add_request(ACT_PIXEL, 24'h654321, 9'd17, 8'd33);
      add_request(ACT_DUMP, 24'h0, 9'd0, 8'd0);
      add_request(ACT_CLEAR, 24'h0, 9'd0, 8'd0);
      add_random_traffic(90);

      // Phase two: sender idles more often than not, random background
      fill_gap_pct = 59;
      upper = 21'($urandom());
      add_csr_write(CSR_BACKGROUND, rand_color());
      add_csr_write(CSR_CELL_SHIFT, {upper, 3'd1});
      add_random_traffic(45);
      upper = 21'($urandom());
      add_csr_write(CSR_CELL_SHIFT, {upper, 3'd2});
      add_random_traffic(45);

      // Phase three: back-to-back requests, black background, 16-pixel cells
      fill_gap_pct = 0;
      add_csr_write(CSR_UNUSED, rand_color());
      add_csr_write(CSR_BACKGROUND, 24'h000000);
      add_csr_write(CSR_CELL_SHIFT, 24'h000004);
      add_random_traffic(95);
   end

   // ------------------------------------------------------------------
   // Driver: take handshakes at the edge, then pick what to present next.
   // start and csr_valid are computed into locals so each gets one update.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      stim_op_type op;
      logic        nxt_start, nxt_csr;
      nxt_start = start;
      nxt_csr   = csr_valid;
      if (reset) begin
         nxt_start = 1'b0;
         nxt_csr   = 1'b0;
      end else begin
         if (start && !busy) begin
            track_request(req_action, req_pixel_color, req_pixel_x, req_pixel_y);
            nxt_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            apply_csr_write(csr_index, csr_data);
            nxt_csr = 1'b0;
         end
         // Hold anything not yet taken; otherwise move on through the plan
         if (!nxt_start && !nxt_csr) begin
            if (settle_cnt != 0) begin
               settle_cnt--;
            end else if (plan.size() == 0) begin
               stim_done = 1'b1;
            end else begin
               op = plan[0];
               case (op.kind)
                  OP_WAIT_IDLE: begin
                     // hold off until every owed response is in and the ring has stopped
                     if (reports_due.size() == 0 && !busy) begin
                        void'(plan.pop_front());
                        settle_cnt = SETTLE_CYCLES;
                     end
                  end
                  OP_CSR_WRITE: begin
                     csr_index <= op.csr_idx;
                     csr_data  <= op.csr_word;
                     nxt_csr = 1'b1;
                     void'(plan.pop_front());
                  end
                  default: begin
                     // drop start for this cycle at the phase's idle rate
                     if ($urandom_range(99) >= op.gap_pct) begin
                        req_action      <= op.action;
                        req_pixel_color <= op.color;
                        req_pixel_x     <= op.x;
                        req_pixel_y     <= op.y;
                        nxt_start = 1'b1;
                        void'(plan.pop_front());
                     end
                  end
               endcase
            end
         end
      end
      start     <= nxt_start;
      csr_valid <= nxt_csr;
   end

   // ------------------------------------------------------------------
   // Monitor: every strobed response is checked against the oldest one owed
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      report_type want;
      if (!reset && rsp_valid) begin
         if (reports_due.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual status %0d label %0d",
                     $time, rsp_status, rsp_label);
            fail_count++;
         end else begin
            want = reports_due.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("label", want.label, rsp_label);
            check_field("entry_color", want.entry.color, rsp_entry_color);
            check_field("box_min_col", want.entry.min_col, rsp_box_min_col);
            check_field("box_end_col", want.entry.end_col, rsp_box_end_col);
            check_field("box_min_row", want.entry.min_row, rsp_box_min_row);
            check_field("box_end_row", want.entry.end_row, rsp_box_end_row);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // ------------------------------------------------------------------
   // End of run: drain, let a dump pass finish, then report
   // ------------------------------------------------------------------
   initial begin
      while (!(stim_done && reports_due.size() == 0)) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && reports_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest legal run
   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

endmodule
